FILE: sv/gtd_pkg.sv
// Shared types and constants for the Goertzel tone detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package gtd_pkg;

   localparam int MaxBlockDefault = 1024;
   localparam int JobDepth        = 2;
   localparam int HalfW           = 16;   // count/2 fits 16 bits up to a 65536-sample block
   localparam int EnergyW         = 48;
   localparam int RhsW            = EnergyW + HalfW;
   localparam logic [15:0] ToneScale = 16'd40960;

   // end-of-block snapshot handed from front to back
   typedef struct packed {
      logic signed [15:0]  coeff;
      logic signed [15:0]  z1;
      logic signed [15:0]  z2;
      logic [EnergyW-1:0]  energy;
      logic [HalfW-1:0]    half;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_SUM,
      ST_CMP
   } state_type;

endpackage

`default_nettype wire

FILE: sv/gtd_front.sv
// Front end: coefficient register, per-sample Goertzel recurrence, energy and count.
// Pushes one job per block end into the job queue. Uses gtd_pkg.
`default_nettype none

module gtd_front import gtd_pkg::*; #(
   parameter int MAX_BLOCK = MaxBlockDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic signed [15:0] req_sample,
   input  wire logic               req_last,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic signed [15:0] csr_coeff_q14,
   input  wire logic               q_full,
   output logic                    q_push,
   output job_type                 q_job
);

   localparam int CntW = $clog2(MAX_BLOCK + 1);

   logic signed [15:0] coeff_ff, coeff_in;
   logic signed [15:0] z1_ff, z1_in;
   logic signed [15:0] z2_ff, z2_in;
   logic [EnergyW-1:0] energy_ff, energy_in;
   logic [CntW-1:0]    count_ff, count_in;

   logic               accept;
   logic signed [31:0] prod;
   logic signed [31:0] sq_x;
   logic signed [19:0] z_sum;
   logic signed [15:0] z_new;
   logic [EnergyW-1:0] energy_new;
   logic [CntW-1:0]    count_new;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   assign prod  = coeff_ff * z1_ff;
   assign z_sum = 20'(req_sample >>> 6) + 20'($signed(prod[31:14])) - 20'(z2_ff);
   assign z_new = z_sum[15:0];
   assign sq_x  = req_sample * req_sample;
   assign energy_new = energy_ff + {{(EnergyW-32){1'b0}}, sq_x};
   assign count_new  = (count_ff == CntW'(MAX_BLOCK)) ? count_ff : count_ff + 1'b1;

   assign q_push       = accept && req_last;
   assign q_job.coeff  = coeff_ff;
   assign q_job.z1     = z_new;
   assign q_job.z2     = z1_ff;
   assign q_job.energy = energy_new;
   assign q_job.half   = HalfW'(count_new >> 1);

   always_comb begin
      coeff_in  = (csr_valid && csr_ready) ? csr_coeff_q14 : coeff_ff;
      z1_in     = z1_ff;
      z2_in     = z2_ff;
      energy_in = energy_ff;
      count_in  = count_ff;
      if (accept) begin
         if (req_last) begin
            z1_in     = '0;
            z2_in     = '0;
            energy_in = '0;
            count_in  = '0;
         end else begin
            z1_in     = z_new;
            z2_in     = z1_ff;
            energy_in = energy_new;
            count_in  = count_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff  <= '0;
         z1_ff     <= '0;
         z2_ff     <= '0;
         energy_ff <= '0;
         count_ff  <= '0;
      end else begin
         coeff_ff  <= coeff_in;
         z1_ff     <= z1_in;
         z2_ff     <= z2_in;
         energy_ff <= energy_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/gtd_queue.sv
// Small job queue between front and back end.
// Register-based ring of job_type entries. Uses gtd_pkg.
`default_nettype none

module gtd_queue import gtd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  job_type      push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         empty,
   output job_type      head
);

   localparam int PtrW = (JobDepth > 1) ? $clog2(JobDepth) : 1;
   localparam int CntW = $clog2(JobDepth + 1);

   job_type         slot_ff [JobDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full    = (count_ff == CntW'(JobDepth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(JobDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(JobDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

FILE: sv/gtd_back.sv
// Back end: per-block power term and tone decision, with the result register.
// Multi-cycle sequencer over staged multiplies. Uses gtd_pkg.
`default_nettype none

module gtd_back import gtd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_empty,
   input  job_type           q_head,
   output logic              q_pop,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output logic signed [31:0] rsp_power,
   output logic              rsp_tone
);

   state_type state_ff, state_in;

   job_type            job_ff;
   logic signed [15:0] m_ff;
   logic signed [31:0] sq1_ff, sq2_ff, mz_ff;
   logic [39:0]        rlo_ff, rhi_ff;
   logic [31:0]        pz_ff;
   logic [RhsW-1:0]    rhs_ff;
   logic               valid_ff, valid_in;
   logic [31:0]        power_ff;
   logic               tone_ff;

   logic signed [31:0] prod;
   logic [RhsW-1:0]    lhs;
   logic               pz_pos;
   logic               done;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!q_empty) state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUM;
         ST_SUM:  state_in = ST_CMP;
         ST_CMP:  if (!valid_ff || rsp_pop) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop = 1'b0;
      done  = 1'b0;
      unique case (state_ff)
         ST_IDLE: q_pop = !q_empty;
         ST_CMP:  done  = !valid_ff || rsp_pop;
         default: begin
            q_pop = 1'b0;
            done  = 1'b0;
         end
      endcase
   end

   assign prod   = job_ff.coeff * job_ff.z1;
   assign pz_pos = !pz_ff[31] && (pz_ff != '0);
   // pz*40960 < 2^47, well inside the rhs width
   assign lhs    = RhsW'(pz_ff[30:0]) * RhsW'(ToneScale);

   always_comb begin
      valid_in = valid_ff;
      if (rsp_pop && valid_ff) valid_in = 1'b0;
      if (done)                valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_head;
      end
      if (state_ff == ST_MUL1) begin
         m_ff   <= prod[29:14];
         sq1_ff <= job_ff.z1 * job_ff.z1;
         sq2_ff <= job_ff.z2 * job_ff.z2;
         rlo_ff <= job_ff.energy[23:0] * job_ff.half;
      end
      if (state_ff == ST_MUL2) begin
         mz_ff  <= m_ff * job_ff.z2;
         rhi_ff <= job_ff.energy[47:24] * job_ff.half;
      end
      if (state_ff == ST_SUM) begin
         pz_ff  <= sq2_ff + sq1_ff - mz_ff;
         rhs_ff <= RhsW'(rlo_ff) + {rhi_ff, 24'b0};
      end
      if (done) begin
         power_ff <= pz_ff;
         tone_ff  <= pz_pos && (lhs > rhs_ff);
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_power = power_ff;
   assign rsp_tone  = tone_ff;

`ifndef SYNTHESIS
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE) && !q_empty)
      else $error("job taken outside idle");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) && valid_ff && !rsp_pop |=> (state_ff == ST_CMP))
      else $error("result overwrote a waiting result");

   a_result_from_cmp: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(state_ff == ST_CMP))
      else $error("result appeared without compare step");
`endif

endmodule

`default_nettype wire

FILE: sv/goertzel_tone_detector_q14.sv
// Result path: queue, then back-end states IDLE, MUL1, MUL2, SUM and CMP.
// Throughput: one sample per cycle while req_full is low; the back end takes a block end
// through its states; a 2-entry job queue buffers block ends and, when full, stalls input.
// Reset: synchronous, active high; clears coefficient, recurrence state, queue and result.
// Uses gtd_pkg, gtd_front, gtd_queue, gtd_back.
`default_nettype none

module goertzel_tone_detector_q14 import gtd_pkg::*; #(
   parameter int MAX_BLOCK = MaxBlockDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic signed [15:0] req_sample,
   input  wire logic               req_last,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic signed [31:0]      rsp_power,
   output logic                    rsp_tone,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic signed [15:0] csr_coeff_q14
);

   job_type push_job;
   job_type head_job;
   logic    q_push, q_full, q_pop, q_empty;

   gtd_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_sample    (req_sample),
      .req_last      (req_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_coeff_q14 (csr_coeff_q14),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (push_job)
   );

   gtd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (head_job)
   );

   gtd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (head_job),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_power (rsp_power),
      .rsp_tone  (rsp_tone)
   );

endmodule

`default_nettype wire
